### rtl/llpbt_pkg.sv
// Shared types and constants for the rangefinder line parser and bin table.
package llpbt_pkg;

  localparam logic [1:0] MODE_BYTE = 2'd0;
  localparam logic [1:0] MODE_TICK = 2'd1;
  localparam logic [1:0] MODE_READ = 2'd2;
  localparam logic [1:0] MODE_NOP  = 2'd3;

  localparam logic [2:0] PH_START = 3'd0;
  localparam logic [2:0] PH_DPRE  = 3'd1;
  localparam logic [2:0] PH_DSIGN = 3'd2;
  localparam logic [2:0] PH_DDIG  = 3'd3;
  localparam logic [2:0] PH_APRE  = 3'd4;
  localparam logic [2:0] PH_ASIGN = 3'd5;
  localparam logic [2:0] PH_ADIG  = 3'd6;
  localparam logic [2:0] PH_DONE  = 3'd7;

  localparam logic [23:0] MAG_CAP = 24'h800000;
  localparam logic [23:0] POS_MAX = 24'h7FFFFF;

  localparam int CMD_W = 2;
  localparam logic [CMD_W-1:0] CMD_STORE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_TICK  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

  // Command handed from the parser front to the table back end.
  typedef struct packed {
    logic [CMD_W-1:0] kind;
    logic [23:0]      angle;     // non-negative angle for a store
    logic [23:0]      distance;  // signed distance for a store
    logic [8:0]       read_bin;
  } cmd_t;

  function automatic logic [23:0] add_digit(input logic [23:0] mag, input logic [3:0] d);
    logic [27:0] v;
    v = {mag, 3'b000} + {3'b000, mag, 1'b0} + {24'd0, d};
    return (v > {4'd0, MAG_CAP}) ? MAG_CAP : v[23:0];
  endfunction

  function automatic logic [23:0] apply_sign(input logic [23:0] mag, input logic neg);
    if (neg) return 24'd0 - mag;
    return (mag > POS_MAX) ? POS_MAX : mag;
  endfunction

endpackage

### rtl/llpbt_ram.sv
// Generic single-port RAM with registered read.
module llpbt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

### rtl/llpbt_front.sv
// Line parser front: consumes input beats and emits table commands.
module llpbt_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            mode,
  input  logic [7:0]            rx_byte,
  input  logic [8:0]            read_bin,
  output logic                  cmd_valid,
  input  logic                  cmd_ready,
  output llpbt_pkg::cmd_t       cmd
);
  import llpbt_pkg::*;

  logic [2:0]  phase;
  logic        neg;
  logic [23:0] dacc, aacc;
  logic [2:0]  phase_next;
  logic        neg_next;
  logic [23:0] dacc_next, aacc_next;
  logic        emit;
  cmd_t        cmd_next;
  logic        digit;
  logic [3:0]  d;
  logic [23:0] afin;
  logic        acc;

  assign in_ready = !cmd_valid || cmd_ready;
  assign acc = in_valid && in_ready;
  assign digit = (rx_byte >= 8'h30) && (rx_byte <= 8'h39);
  assign d = rx_byte[3:0] - 4'd0;

  always_comb begin
    phase_next = phase;
    neg_next = neg;
    dacc_next = dacc;
    aacc_next = aacc;
    emit = 1'b0;
    cmd_next = '0;
    cmd_next.read_bin = read_bin;
    afin = aacc;
    unique case (mode)
      MODE_TICK: begin
        emit = 1'b1;
        cmd_next.kind = CMD_TICK;
      end
      MODE_READ: begin
        emit = 1'b1;
        cmd_next.kind = CMD_READ;
      end
      MODE_BYTE: begin
        if (rx_byte == 8'd10) begin
          if (phase == PH_ADIG) afin = apply_sign(aacc, neg);
          if ((phase == PH_ADIG || phase == PH_DONE) && !afin[23]) begin
            emit = 1'b1;
            cmd_next.kind = CMD_STORE;
            cmd_next.angle = afin;
            cmd_next.distance = dacc;
          end
          phase_next = PH_START;
          neg_next = 1'b0;
          dacc_next = '0;
          aacc_next = '0;
        end else if (rx_byte >= 8'h20) begin
          unique case (phase)
            PH_START: begin
              if (rx_byte == 8'h73) phase_next = PH_DPRE;
              else begin phase_next = PH_DONE; aacc_next = '1; end
            end
            PH_DPRE, PH_APRE: begin
              if (rx_byte == 8'h20) begin
              end else if (rx_byte == 8'h2B || rx_byte == 8'h2D) begin
                neg_next = (rx_byte == 8'h2D);
                phase_next = phase + 3'd1;
              end else if (digit) begin
                neg_next = 1'b0;
                if (phase == PH_DPRE) dacc_next = {20'd0, d};
                else aacc_next = {20'd0, d};
                phase_next = phase + 3'd2;
              end else begin
                phase_next = PH_DONE; aacc_next = '1;
              end
            end
            PH_DSIGN, PH_ASIGN: begin
              if (digit) begin
                if (phase == PH_DSIGN) dacc_next = {20'd0, d};
                else aacc_next = {20'd0, d};
                phase_next = phase + 3'd1;
              end else begin
                phase_next = PH_DONE; aacc_next = '1;
              end
            end
            PH_DDIG: begin
              if (digit) dacc_next = add_digit(dacc, d);
              else if (rx_byte == 8'h2C) begin
                dacc_next = apply_sign(dacc, neg);
                neg_next = 1'b0;
                aacc_next = '0;
                phase_next = PH_APRE;
              end else begin
                phase_next = PH_DONE; aacc_next = '1;
              end
            end
            PH_ADIG: begin
              if (digit) aacc_next = add_digit(aacc, d);
              else begin
                aacc_next = apply_sign(aacc, neg);
                phase_next = PH_DONE;
              end
            end
            default: begin
            end
          endcase
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_START;
      neg <= 1'b0;
      dacc <= '0;
      aacc <= '0;
      cmd_valid <= 1'b0;
    end else begin
      if (acc) begin
        phase <= phase_next;
        neg <= neg_next;
        dacc <= dacc_next;
        aacc <= aacc_next;
      end
      if (acc && emit) begin
        cmd_valid <= 1'b1;
        cmd <= cmd_next;
      end else if (cmd_ready) begin
        cmd_valid <= 1'b0;
      end
    end
  end
endmodule

### rtl/llpbt_back.sv
// Table back end: bin scaling divider, bin memories, age sweep and reads.
module llpbt_back #(
  parameter int BINS = 360
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [15:0]      angle_full_scale,
  input  logic [9:0]       expiry_limit,
  input  logic             cmd_valid,
  output logic             cmd_ready,
  input  llpbt_pkg::cmd_t  cmd,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [23:0]      bin_distance,
  output logic [9:0]       bin_age
);
  import llpbt_pkg::*;

  localparam int AW = $clog2(BINS);
  localparam int PW = 24 + AW + 1;  // angle*BINS product width
  localparam int CW = $clog2(PW + 1);

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_MUL   = 7'b0000100,
    S_DIV   = 7'b0001000,
    S_SWEEP = 7'b0010000,
    S_READ  = 7'b0100000,
    S_RWAIT = 7'b1000000
  } state_t;

  state_t state;
  logic [AW-1:0] idx;
  logic [AW-1:0] addr;
  logic          we;
  logic [23:0]   wd_dist;
  logic [9:0]    wd_age;
  logic [23:0]   rd_dist;
  logic [9:0]    rd_age;
  logic          sweep_rd;
  logic [PW-1:0] num;
  logic [15:0]   rem;
  logic [CW-1:0] cnt;
  logic [23:0]   sdist;
  logic          rd_oob;
  logic [16:0]   trial;
  logic [10:0]   age_inc;

  llpbt_ram #(.WIDTH(24), .DEPTH(BINS)) u_dist (
    .clk(clk), .we(we), .addr(addr), .wdata(wd_dist), .rdata(rd_dist));
  llpbt_ram #(.WIDTH(10), .DEPTH(BINS)) u_age (
    .clk(clk), .we(we), .addr(addr), .wdata(wd_age), .rdata(rd_age));

  assign cmd_ready = (state == S_IDLE) && !out_valid;
  assign trial = {rem, num[PW-1]};
  assign age_inc = {1'b0, rd_age} + 11'd1;

  always_comb begin
    we = 1'b0;
    addr = idx;
    wd_dist = '0;
    wd_age = '0;
    unique case (state)
      S_CLEAR: we = 1'b1;
      S_DIV: begin
        addr = num[AW-1:0];
        if (cnt == '0 && num < PW'(BINS)) begin
          we = 1'b1;
          wd_dist = sdist;
        end
      end
      S_SWEEP: begin
        if (sweep_rd) begin
          we = 1'b1;
          if (age_inc > {1'b0, expiry_limit}) wd_age = '0;
          else begin
            wd_age = age_inc[9:0];
            wd_dist = rd_dist;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      idx <= '0;
      out_valid <= 1'b0;
      sweep_rd <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          if (idx == AW'(BINS - 1)) begin idx <= '0; state <= S_IDLE; end
          else idx <= idx + 1'b1;
        end
        S_IDLE: begin
          if (cmd_valid && cmd_ready) begin
            unique case (cmd.kind)
              CMD_STORE: begin
                if (angle_full_scale != 16'd0) begin
                  num <= PW'(cmd.angle);
                  sdist <= cmd.distance;
                  state <= S_MUL;
                end
              end
              CMD_TICK: begin
                idx <= '0;
                sweep_rd <= 1'b0;
                state <= S_SWEEP;
              end
              CMD_READ: begin
                rd_oob <= ({23'd0, cmd.read_bin} >= 32'(BINS));
                idx <= AW'(cmd.read_bin);
                state <= S_READ;
              end
              default: begin
              end
            endcase
          end
        end
        S_MUL: begin
          num <= PW'(num * PW'(BINS));
          rem <= '0;
          cnt <= CW'(PW);
          state <= S_DIV;
        end
        S_DIV: begin
          // Restoring division, one quotient bit per cycle.
          if (cnt != '0) begin
            if (trial >= {1'b0, angle_full_scale}) begin
              rem <= 16'(trial - {1'b0, angle_full_scale});
              num <= {num[PW-2:0], 1'b1};
            end else begin
              rem <= trial[15:0];
              num <= {num[PW-2:0], 1'b0};
            end
            cnt <= cnt - 1'b1;
          end else state <= S_IDLE;
        end
        S_SWEEP: begin
          // Read at idx, write back in the next cycle at the same address.
          if (!sweep_rd) sweep_rd <= 1'b1;
          else begin
            sweep_rd <= 1'b0;
            if (idx == AW'(BINS - 1)) begin idx <= '0; state <= S_IDLE; end
            else idx <= idx + 1'b1;
          end
        end
        S_READ: state <= S_RWAIT;
        S_RWAIT: begin
          out_valid <= 1'b1;
          bin_distance <= rd_oob ? 24'd0 : rd_dist;
          bin_age <= rd_oob ? 10'd0 : rd_age;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

### rtl/lidar_line_parse_bin_table_top.sv
// Top level of the rangefinder line parser with angular bin table.
//
// Input beats on s_axis carry a mode in tuser: a received character, an age
// tick, or a read of one bin. Characters build lines "s<distance>,<angle>"
// closed by a newline; a valid line stores its distance in bin
// angle*BINS/full_scale and resets that bin's age. An age tick ages every bin
// and clears expired ones. A read returns one beat on m_axis with the bin's
// distance and age.
// The front parser takes one beat per cycle while its one-entry command
// register is free. The back end runs one command at a time: a store
// multiplies the angle by BINS, then forms one quotient bit per cycle for
// the 34-bit product at 360 bins and writes the bin; an age tick reads and
// writes back each bin on a single-port RAM. With the back end idle, a read
// passes the command register, S_READ and S_RWAIT before its result is
// offered. After reset the back end clears both tables and accepts no
// commands meanwhile; the parser still takes characters until its command
// register fills. When the receiver stalls, the result stays in the output
// register and the back end halts; the parser's command register then fills
// and s_axis_tready falls. Configuration writes are taken at any time.
module lidar_line_parse_bin_table_top #(
  parameter int BINS = 360
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_wdata,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // rx_byte[7:0], read_bin[16:8]
  input  logic [1:0]  s_axis_tuser,   // mode[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata    // bin_distance[23:0], bin_age[33:24]
);
  import llpbt_pkg::*;

  logic [15:0] angle_full_scale;
  logic [9:0]  expiry_limit;
  logic        cmd_valid, cmd_ready;
  cmd_t        cmd;
  logic [23:0] bin_distance;
  logic [9:0]  bin_age;

  always_ff @(posedge clk) begin
    if (rst) begin
      angle_full_scale <= 16'd22900;
      expiry_limit <= 10'd300;
    end else if (cfg_we) begin
      if (cfg_index == 1'b0) angle_full_scale <= cfg_wdata;
      else expiry_limit <= cfg_wdata[9:0];
    end
  end

  llpbt_front u_front (
    .clk(clk), .rst(rst),
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .mode(s_axis_tuser), .rx_byte(s_axis_tdata[7:0]),
    .read_bin(s_axis_tdata[16:8]),
    .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd));

  llpbt_back #(.BINS(BINS)) u_back (
    .clk(clk), .rst(rst),
    .angle_full_scale(angle_full_scale), .expiry_limit(expiry_limit),
    .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .bin_distance(bin_distance), .bin_age(bin_age));

  assign m_axis_tdata = {6'd0, bin_age, bin_distance};
endmodule

### sim/lidar_line_parse_bin_table_top_test.sv
// Self-checking testbench for the rangefinder line parser and bin table.
`timescale 1ns / 1ps

module lidar_line_parse_bin_table_top_test;
  import llpbt_pkg::*;

  localparam int NBINS = 360;
  localparam int LIMIT_CYCLES = 3000000;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic        cfg_index;
  logic [15:0] cfg_wdata;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata;
  logic [1:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [39:0] m_axis_tdata;

  lidar_line_parse_bin_table_top #(.BINS(NBINS)) uut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready), .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
  );

  // Predicted configuration and parser state, kept at the block's widths.
  logic [15:0] full_scale;
  logic [9:0]  age_limit;
  logic [2:0]  phase;
  logic        negative;
  logic [23:0] dist_acc;
  logic [23:0] ang_acc;
  logic [23:0] dist_store [NBINS];
  logic [9:0]  age_store [NBINS];

  // Expected read results, oldest first: {age, distance}.
  logic [33:0] pending_reads [$];
  int mismatches;
  int reads_seen;
  int lines_sent;
  int cycle_count;
  int burst_left;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic logic [23:0] digit_in(logic [23:0] mag, logic [7:0] c);
    logic [31:0] v;
    v = {8'd0, mag} * 32'd10 + {24'd0, c - 8'h30};
    return (v > 32'h800000) ? 24'h800000 : v[23:0];
  endfunction

  function automatic logic [23:0] signed_val(logic [23:0] mag, logic neg);
    if (neg) return 24'd0 - mag;
    return (mag > 24'h7FFFFF) ? 24'h7FFFFF : mag;
  endfunction

  task automatic predict_commit();
    logic [63:0] bin;
    if (phase == PH_ADIG) begin
      ang_acc = signed_val(ang_acc, negative);
      phase = PH_DONE;
    end
    if (phase == PH_DONE && !ang_acc[23] && full_scale != 0) begin
      bin = ({40'd0, ang_acc} * NBINS) / full_scale;
      if (bin < NBINS) begin
        dist_store[bin[8:0]] = dist_acc;
        age_store[bin[8:0]] = '0;
      end
    end
  endtask

  task automatic predict_byte(logic [7:0] c);
    logic dig;
    dig = (c >= 8'h30 && c <= 8'h39);
    if (c == 8'd10) begin
      predict_commit();
      phase = PH_START; negative = 1'b0; dist_acc = '0; ang_acc = '0;
    end else if (c >= 8'h20) begin
      case (phase)
        PH_START: begin
          if (c == "s") phase = PH_DPRE;
          else begin phase = PH_DONE; ang_acc = '1; end
        end
        PH_DPRE, PH_APRE: begin
          if (c == " ") begin
          end else if (c == "+" || c == "-") begin
            negative = (c == "-");
            phase = phase + 3'd1;
          end else if (dig) begin
            negative = 1'b0;
            if (phase == PH_DPRE) dist_acc = {16'd0, c - 8'h30};
            else ang_acc = {16'd0, c - 8'h30};
            phase = phase + 3'd2;
          end else begin
            phase = PH_DONE; ang_acc = '1;
          end
        end
        PH_DSIGN, PH_ASIGN: begin
          if (dig) begin
            if (phase == PH_DSIGN) dist_acc = {16'd0, c - 8'h30};
            else ang_acc = {16'd0, c - 8'h30};
            phase = phase + 3'd1;
          end else begin
            phase = PH_DONE; ang_acc = '1;
          end
        end
        PH_DDIG: begin
          if (dig) dist_acc = digit_in(dist_acc, c);
          else if (c == ",") begin
            dist_acc = signed_val(dist_acc, negative);
            negative = 1'b0; ang_acc = '0; phase = PH_APRE;
          end else begin
            phase = PH_DONE; ang_acc = '1;
          end
        end
        PH_ADIG: begin
          if (dig) ang_acc = digit_in(ang_acc, c);
          else begin
            ang_acc = signed_val(ang_acc, negative);
            phase = PH_DONE;
          end
        end
        default: ;
      endcase
    end
  endtask

  task automatic predict_tick();
    logic [10:0] a;
    for (int i = 0; i < NBINS; i++) begin
      a = {1'b0, age_store[i]} + 11'd1;
      if (a > {1'b0, age_limit}) begin
        dist_store[i] = '0; age_store[i] = '0;
      end else age_store[i] = a[9:0];
    end
  endtask

  // Send one beat with a bursty sender; the model is updated on acceptance.
  task automatic send_beat(logic [1:0] mode, logic [7:0] c, logic [8:0] rb);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : 0;
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 30);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {7'd0, rb, c};
    s_axis_tuser <= mode;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    case (mode)
      MODE_BYTE: predict_byte(c);
      MODE_TICK: predict_tick();
      MODE_READ: begin
        if (rb < NBINS) pending_reads.push_back({age_store[rb], dist_store[rb]});
        else pending_reads.push_back('0);
      end
      default: ;
    endcase
  endtask

  task automatic send_text(string txt);
    for (int i = 0; i < txt.len(); i++) send_beat(MODE_BYTE, txt[i], 9'($urandom));
  endtask

  task automatic read_bin(int b);
    send_beat(MODE_READ, 8'($urandom), b[8:0]);
  endtask

  // Wait until every read has come back, then let the back end drain.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending_reads.size() != 0) @(posedge clk);
    repeat (2 * NBINS + 100) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [15:0] val);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == 1'b0) full_scale = val;
    else age_limit = val[9:0];
  endtask

  // Checker: each result beat against the oldest expectation.
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      reads_seen++;
      if (pending_reads.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result beat %h", m_axis_tdata);
      end else begin
        logic [33:0] exp_r;
        exp_r = pending_reads.pop_front();
        if (m_axis_tdata[23:0] !== exp_r[23:0] || m_axis_tdata[33:24] !== exp_r[33:24]
            || m_axis_tdata[39:34] !== 6'd0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Read mismatch: distance exp %h got %h, age exp %0d got %0d",
                     exp_r[23:0], m_axis_tdata[23:0], exp_r[33:24], m_axis_tdata[33:24]);
        end
      end
    end
  end

  // Receiver stalls on its own pattern: long open stretches, then stall runs.
  always @(posedge clk) begin
    int r;
    r = $urandom_range(0, 99);
    if (cycle_count % 3000 < 1200) m_axis_tready <= 1'b1;
    else m_axis_tready <= (r < 60);
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Build a random line, mostly well formed, sometimes broken.
  task automatic random_line();
    string s;
    int kind;
    kind = $urandom_range(0, 9);
    s = "s";
    repeat ($urandom_range(0, 2)) s = {s, " "};
    if ($urandom_range(0, 3) == 0) s = {s, ($urandom_range(0, 1) ? "-" : "+")};
    if ($urandom_range(0, 15) == 0) s = {s, "99999999"};
    else s = {s, $sformatf("%0d", $urandom_range(0, 9999))};
    if (kind == 0) s = {s, ";"}; else s = {s, ","};
    if ($urandom_range(0, 3) == 0) s = {s, " "};
    if (kind == 1) s = {s, "-"};
    else if ($urandom_range(0, 7) == 0) s = {s, "+"};
    s = {s, $sformatf("%0d", $urandom_range(0, full_scale + 200))};
    if (kind == 2) s = {s, $sformatf("e%c%c", 8'd9, 8'($urandom_range(128, 255)))};
    if (kind == 3) s = {$sformatf("%c", 8'($urandom_range(33, 255))), s};
    send_text(s);
    send_beat(MODE_BYTE, 8'd10, 9'($urandom));
    lines_sent++;
  endtask

  task automatic test_directed();
    send_text("s1234,100\n");
    read_bin(1);
    send_text("s  -8388608, +22899\n");
    read_bin(359);
    send_text("s99999999,0\n");
    read_bin(0);
    send_text("s-0,-0\n");
    read_bin(0);
    send_text("s5,-7\ns+,5\ns7,22900\n");
    send_text($sformatf("s4%c2,%c\n", 8'd13, 8'd255));
    send_beat(MODE_BYTE, 8'hFF, 9'h1FF);
    send_beat(MODE_NOP, 8'hFF, 9'h1FF);
    send_text("\ns42,63abc\n");
    read_bin(0);
    read_bin(NBINS);
    read_bin(511);
    send_beat(MODE_TICK, 8'h00, 9'h000);
    read_bin(0);
    lines_sent += 8;
    settle();
  endtask

  task automatic test_config_extremes();
    write_reg(1'b0, 16'd1);
    write_reg(1'b1, 16'd1);
    send_text("s77,0\ns88,1\n");
    read_bin(0);
    send_beat(MODE_TICK, 8'd0, 9'd0);
    read_bin(0);
    send_beat(MODE_TICK, 8'd0, 9'd0);
    read_bin(0);
    settle();
    write_reg(1'b0, 16'd65535);
    write_reg(1'b1, 16'd1023);
    send_text("s-5,65534\ns6,65535\n");
    read_bin(359);
    lines_sent += 4;
    settle();
  endtask

  task automatic test_random(int items, logic [15:0] fs, logic [9:0] lim);
    int n;
    write_reg(1'b0, fs);
    write_reg(1'b1, {6'd0, lim});
    n = 0;
    while (n < items) begin
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        random_line(); n += 12;
      end else if (pick < 60) begin
        send_beat(MODE_BYTE, 8'($urandom), 9'($urandom)); n++;
      end else if (pick < 65) begin
        send_beat(MODE_TICK, 8'($urandom), 9'($urandom)); n++;
      end else if (pick < 67) begin
        send_beat(MODE_NOP, 8'($urandom), 9'($urandom)); n++;
      end else begin
        read_bin($urandom_range(0, 5) == 0 ? $urandom_range(0, 511)
                                            : $urandom_range(0, NBINS - 1));
        n++;
      end
    end
    settle();
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0; cfg_index = 1'b0; cfg_wdata = '0;
    s_axis_tvalid = 1'b0; s_axis_tdata = '0; s_axis_tuser = '0;
    m_axis_tready = 1'b0;
    mismatches = 0; reads_seen = 0; lines_sent = 0; cycle_count = 0; burst_left = 0;
    full_scale = 16'd22900; age_limit = 10'd300;
    phase = PH_START; negative = 1'b0; dist_acc = '0; ang_acc = '0;
    for (int i = 0; i < NBINS; i++) begin
      dist_store[i] = '0; age_store[i] = '0;
    end
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_config_extremes();
    test_random(700, 16'd360, 10'd3);
    test_random(700, 16'd22900, 10'd8);
    test_random(600, 16'd1000, 10'd1023);
    $display("Covered %0d lines and %0d read results across five register settings.",
             lines_sent, reads_seen);
    if (mismatches == 0 && pending_reads.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d mismatches, %0d reads outstanding", mismatches, pending_reads.size());
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
